// ===== hw/rtl/rfw_pkg.sv =====
// ----------------------------------------------------------------------------
// rfw_pkg: shared types and codes of the repeat field frame weaver
// Transfer payloads, picture type decode and status codes.
// ----------------------------------------------------------------------------
package rfw_pkg;

   localparam int POS_W    = 16;
   localparam int SMP_W    = 16;
   localparam int REP_W    = 3;
   localparam int STATUS_W = 2;
   localparam int COPY_W   = 2;

   localparam logic [STATUS_W-1:0] ST_OK                = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_REPEAT        = 2'd1;
   localparam logic [STATUS_W-1:0] ST_INTERLACED_REPEAT = 2'd2;

   localparam logic [REP_W-1:0] REP_NONE   = 3'd0;
   localparam logic [REP_W-1:0] REP_FIELD  = 3'd1;
   localparam logic [REP_W-1:0] REP_DOUBLE = 3'd2;
   localparam logic [REP_W-1:0] REP_TRIPLE = 3'd4;

   typedef struct packed {
      logic [SMP_W-1:0] sample;
      logic [POS_W-1:0] position;
      logic             odd_line;
      logic             interlaced;
      logic             top_first;
      logic [REP_W-1:0] repeat_count;
      logic             end_of_frame;
   } req_type;

   typedef struct packed {
      logic [SMP_W-1:0]    out_sample;
      logic [POS_W-1:0]    out_position;
      logic [COPY_W-1:0]   copy_index;
      logic                last_of_run;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COPY_W-1:0]   copies;
      logic                weave_first;
   } decode_type;

   // Picture type from the frame flags
   function automatic decode_type decode_picture(req_type r);
      decode_type d;
      d.status      = ST_OK;
      d.copies      = 2'd1;
      d.weave_first = 1'b0;
      if (r.interlaced) begin
         if (r.repeat_count != REP_NONE) begin
            d.status = ST_INTERLACED_REPEAT;
         end else begin
            d.weave_first = !r.top_first;
         end
      end else begin
         unique case (r.repeat_count)
            REP_NONE: begin
               d.copies = 2'd1;
            end
            REP_FIELD: begin
               if (!r.top_first) begin
                  d.weave_first = 1'b1;
                  d.copies      = 2'd2;
               end
            end
            REP_DOUBLE: begin
               d.copies = 2'd2;
            end
            REP_TRIPLE: begin
               d.copies = 2'd3;
            end
            default: begin
               d.status = ST_BAD_REPEAT;
            end
         endcase
      end
      return d;
   endfunction

endpackage

// ===== hw/rtl/rfw_ram.sv =====
// ----------------------------------------------------------------------------
// rfw_ram: generic simple dual port RAM
// One write port, one read port, registered read, read-first on collision.
// ----------------------------------------------------------------------------
module rfw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/rfw_wrap.sv =====
// ----------------------------------------------------------------------------
// rfw_wrap: store address reduction
// Two stage pipeline: position modulo FRAME_SAMPLES by reciprocal multiply.
// ----------------------------------------------------------------------------
module rfw_wrap import rfw_pkg::*; #(
   parameter int FRAME_SAMPLES = 65536,
   localparam int ADDR_W = $clog2(FRAME_SAMPLES)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  req_type           in_data,
   output logic              in_ready,
   input  logic              take,
   output logic              out_valid,
   output req_type           out_data,
   output logic [ADDR_W-1:0] out_addr
);

   // floor(pos / F) = (pos * RECIP) >> SHIFT exactly for any POS_W-bit pos
   localparam int SHIFT = POS_W + ADDR_W;
   localparam longint unsigned RECIP =
      ((64'd1 << SHIFT) + longint'(FRAME_SAMPLES) - 64'd1) / longint'(FRAME_SAMPLES);
   localparam int RECIP_W = POS_W + 2;
   localparam int PROD1_W = POS_W + RECIP_W;
   localparam int F_W     = ADDR_W + 1;
   localparam int PROD2_W = POS_W + F_W;
   localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
   localparam logic [F_W-1:0]     FRAME_C = F_W'(FRAME_SAMPLES);

   logic               s1_valid_ff;
   req_type            s1_req_ff;
   logic [PROD1_W-1:0] s1_prod_ff;
   logic               s2_valid_ff;
   req_type            s2_req_ff;
   logic [PROD2_W-1:0] s2_qf_ff;

   logic               s1_load;
   logic               s2_load;
   logic [POS_W-1:0]   quot;
   logic [PROD2_W-1:0] diff;

   assign s2_load  = !s2_valid_ff || take;
   assign s1_load  = !s1_valid_ff || s2_load;
   assign in_ready = s1_load;
   assign quot     = POS_W'(s1_prod_ff >> SHIFT);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_load) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_req_ff  <= in_data;
         s1_prod_ff <= PROD1_W'(in_data.position) * PROD1_W'(RECIP_C);
      end
      if (s2_load) begin
         s2_req_ff <= s1_req_ff;
         s2_qf_ff  <= PROD2_W'(quot) * PROD2_W'(FRAME_C);
      end
   end

   assign diff      = PROD2_W'(s2_req_ff.position) - s2_qf_ff;
   assign out_addr  = diff[ADDR_W-1:0];
   assign out_valid = s2_valid_ff;
   assign out_data  = s2_req_ff;

endmodule

// ===== hw/rtl/rfw_emit.sv =====
// ----------------------------------------------------------------------------
// rfw_emit: copy sequencer and result register
// Holds one item with its stored sample and issues its copies one a cycle unless stalled.
// ----------------------------------------------------------------------------
module rfw_emit import rfw_pkg::*; #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  req_type                in_data,
   input  decode_type             in_dec,
   input  logic                   in_prev,
   output logic                   in_ready,
   input  logic [SAMPLE_BITS-1:0] rd_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data
);

   logic              item_valid_ff;
   req_type           item_ff;
   decode_type        dec_ff;
   logic              prev_ff;
   logic [COPY_W-1:0] copy_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   logic              out_free;
   logic              fire;
   logic              last;
   logic              done;
   logic [SMP_W-1:0]  smp;
   logic [SMP_W-1:0]  woven;
   rsp_type           rsp_data_in;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign fire     = item_valid_ff && out_free;
   assign last     = copy_ff == dec_ff.copies - 2'd1;
   assign done     = fire && last;
   assign in_ready = !item_valid_ff || done;

   assign smp   = SMP_W'(item_ff.sample[SAMPLE_BITS-1:0]);
   assign woven = (!item_ff.odd_line && prev_ff) ? SMP_W'(rd_data) : smp;

   always_comb begin
      rsp_data_in.out_position = item_ff.position;
      rsp_data_in.copy_index   = copy_ff;
      rsp_data_in.last_of_run  = last;
      rsp_data_in.status       = dec_ff.status;
      if (dec_ff.status != ST_OK) begin
         rsp_data_in.out_sample = '0;
      end else if (copy_ff == '0 && dec_ff.weave_first) begin
         rsp_data_in.out_sample = woven;
      end else begin
         rsp_data_in.out_sample = smp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         copy_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (in_valid && in_ready) begin
            item_valid_ff <= 1'b1;
            copy_ff       <= '0;
         end else if (done) begin
            item_valid_ff <= 1'b0;
         end else if (fire) begin
            copy_ff <= copy_ff + 2'd1;
         end
         if (out_free) begin
            rsp_valid_ff <= fire;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_data;
         dec_ff  <= in_dec;
         prev_ff <= in_prev;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/repeat_field_frame_weaver.sv =====
// ----------------------------------------------------------------------------
// repeat_field_frame_weaver: soft telecine repeat field handling
// Turns each input sample into one to three output copies, weaving bottom
// field first pictures with the stored previous frame.
// ----------------------------------------------------------------------------
// Samples stream in one per transfer and leave as result transfers, one per
// output frame copy (one to three per input, tagged copy_index 0..2, with
// last_of_run on the final one). The result port carries one transfer per
// cycle while rsp_stall is low, and a sample holds the copy sequencer until
// its last copy leaves: one copy for pass-through and weave-only pictures,
// two for doubling and weave-then-current, three for tripling; error results
// have one copy. A new sample is taken every cycle while the copy sequencer
// keeps up. A sample passes four register stages: two of address reduction
// (position modulo FRAME_SAMPLES by reciprocal multiply), the frame store
// read together with the copy sequencer load, and the result register, which
// presents its results. The frame store is one FRAME_SAMPLES x SAMPLE_BITS
// memory read and written in the same cycle for the same sample (old data is
// returned), so a following sample at the same position sees the value this
// one wrote (an error result writes nothing). The store needs no clearing
// after reset; weaving against a position the previous frame never wrote
// returns an unspecified value.
// ----------------------------------------------------------------------------
module repeat_field_frame_weaver import rfw_pkg::*; #(
   parameter int FRAME_SAMPLES = 65536,
   parameter int SAMPLE_BITS   = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int ADDR_W = $clog2(FRAME_SAMPLES);

   logic                   req_ready;
   logic                   acc_valid;
   req_type                acc_req;
   logic [ADDR_W-1:0]      acc_addr;
   decode_type             acc_dec;
   logic                   emit_ready;
   logic                   take;
   logic                   store_wr;
   logic [SAMPLE_BITS-1:0] store_rd_data;
   logic                   prev_valid_ff;
   logic                   prev_valid_in;

   // Reduce position to a store address
   rfw_wrap #(
      .FRAME_SAMPLES(FRAME_SAMPLES)
   ) u_wrap (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_data  (req_data),
      .in_ready (req_ready),
      .take     (take),
      .out_valid(acc_valid),
      .out_data (acc_req),
      .out_addr (acc_addr)
   );

   assign req_stall = !req_ready;

   // Access stage: read the previous frame's sample and replace it with the
   // current one in the same cycle; errors leave the store untouched
   assign acc_dec  = decode_picture(acc_req);
   assign take     = acc_valid && emit_ready;
   assign store_wr = take && acc_dec.status == ST_OK;

   rfw_ram #(
      .WIDTH(SAMPLE_BITS),
      .DEPTH(FRAME_SAMPLES)
   ) u_store (
      .clock  (clock),
      .wr_en  (store_wr),
      .wr_addr(acc_addr),
      .wr_data(acc_req.sample[SAMPLE_BITS-1:0]),
      .rd_en  (take),
      .rd_addr(acc_addr),
      .rd_data(store_rd_data)
   );

   // Mark a previous frame present once a frame's last sample is stored
   assign prev_valid_in = prev_valid_ff || (store_wr && acc_req.end_of_frame);

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_valid_ff <= 1'b0;
      end else begin
         prev_valid_ff <= prev_valid_in;
      end
   end

   // Sequence the copies out; the flag travels as seen before this sample
   rfw_emit #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_emit (
      .clock    (clock),
      .reset    (reset),
      .in_valid (acc_valid),
      .in_data  (acc_req),
      .in_dec   (acc_dec),
      .in_prev  (prev_valid_ff),
      .in_ready (emit_ready),
      .rd_data  (store_rd_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule
